// ----- rtl/kfd_pkg.sv -----
// Shared types and constants for the KISS frame deframer.
// No dependencies; every other file of the block but kfd_ram uses this package.
package kfd_pkg;

	localparam int FRAME_BYTES = 512;
	localparam int ADDR_W = $clog2(FRAME_BYTES);
	localparam int FILL_W = $clog2(FRAME_BYTES + 1);
	localparam int RAM_AW = ADDR_W + 1;
	localparam int RAM_DEPTH = 2 ** RAM_AW;

	localparam int BYTE_W = 8;
	localparam int BYTES_PER_WORD = 8;
	localparam int WORD_W = BYTE_W * BYTES_PER_WORD;
	localparam int LANE_W = $clog2(BYTES_PER_WORD);
	localparam int CNT_W = 4;
	localparam int PLEN_W = 9;
	localparam int PORT_W = 8;

	localparam logic [BYTE_W-1:0] FEND_CODE = 8'hC0;
	localparam logic [BYTE_W-1:0] FESC_CODE = 8'hDB;
	localparam logic [BYTE_W-1:0] TFEND_CODE = 8'hDC;
	localparam logic [BYTE_W-1:0] TFESC_CODE = 8'hDD;
	localparam logic [3:0] CMD_NIBBLE_MASK = 4'hF;
	localparam logic [3:0] CMD_DATA = 4'h0;

	// Closed frame handed from the receive side to the drain side.
	typedef struct packed {
		logic bank;
		logic [ADDR_W-1:0] plen;
	} desc_t;

	// Store bank handed back once the drain side has read it out.
	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FETCH,
		BK_WAIT,
		BK_LOAD
	} back_state_t;

endpackage

// ----- rtl/kfd_ifs.sv -----
// Channel interfaces of the KISS frame deframer: received bytes, frame words
// and the port number write channel. Depends on kfd_pkg.
interface kfd_byte_if;
	logic valid;
	logic ready;
	logic [kfd_pkg::BYTE_W-1:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface kfd_word_if;
	logic valid;
	logic ready;
	logic [kfd_pkg::WORD_W-1:0] frame_word;
	logic [kfd_pkg::CNT_W-1:0] byte_count;
	logic last_word;
	logic [kfd_pkg::PLEN_W-1:0] payload_length;
	logic [kfd_pkg::PORT_W-1:0] port_out;
	modport source (output valid, output frame_word, output byte_count, output last_word,
		output payload_length, output port_out, input ready);
	modport sink (input valid, input frame_word, input byte_count, input last_word,
		input payload_length, input port_out, output ready);
endinterface

interface kfd_cfg_if;
	logic valid;
	logic ready;
	logic [kfd_pkg::PORT_W-1:0] port_number;
	modport source (output valid, output port_number, input ready);
	modport sink (input valid, input port_number, output ready);
endinterface

// ----- rtl/kfd_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ----- rtl/kfd_desc_fifo.sv -----
// Two-entry queue of closed-frame descriptors between receive and drain sides.
// Depends on kfd_pkg.
module kfd_desc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  kfd_pkg::desc_t  wdata,
	input  logic            pop,
	output kfd_pkg::desc_t  rdata,
	output logic            empty
);
	import kfd_pkg::*;

	desc_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign rdata = entry_q[rd_ptr_q];
	assign empty = (count_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ----- rtl/kfd_front.sv -----
// Receive side: sync tracking, escape removal, frame store writes and frame
// close decisions. Depends on kfd_pkg.
module kfd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [kfd_pkg::BYTE_W-1:0] in_byte,
	output logic                       in_ready,
	output logic                       wr_en,
	output logic [kfd_pkg::RAM_AW-1:0] wr_addr,
	output logic [kfd_pkg::BYTE_W-1:0] wr_data,
	output logic                       push,
	output kfd_pkg::desc_t             push_desc,
	input  kfd_pkg::release_t          rel
);
	import kfd_pkg::*;

	logic in_sync_q;
	logic esc_q;
	logic [FILL_W-1:0] fill_q;
	logic cmd_ok_q;
	logic bank_q;
	logic [1:0] busy_q;

	logic accept;
	logic is_fend;
	logic store_req;
	logic room;
	logic frame_ok;
	logic [BYTE_W-1:0] dec_byte;

	assign in_ready = !busy_q[bank_q];
	assign accept = in_valid && in_ready;
	assign is_fend = (in_byte == FEND_CODE);

	always_comb begin
		dec_byte = in_byte;
		if (esc_q) begin
			if (in_byte == TFEND_CODE) begin
				dec_byte = FEND_CODE;
			end else if (in_byte == TFESC_CODE) begin
				dec_byte = FESC_CODE;
			end
		end
	end

	assign store_req = accept && !is_fend && in_sync_q && (esc_q || (in_byte != FESC_CODE));
	assign room = (fill_q < FILL_W'(FRAME_BYTES));
	assign frame_ok = in_sync_q && (fill_q > FILL_W'(1)) && cmd_ok_q;

	assign wr_en = store_req && room;
	assign wr_addr = {bank_q, fill_q[ADDR_W-1:0]};
	assign wr_data = dec_byte;

	assign push = accept && is_fend && frame_ok;
	assign push_desc.bank = bank_q;
	assign push_desc.plen = ADDR_W'(fill_q - FILL_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sync_q <= 1'b0;
			esc_q <= 1'b0;
			fill_q <= '0;
			cmd_ok_q <= 1'b0;
			bank_q <= 1'b0;
		end else if (accept) begin
			if (is_fend) begin
				in_sync_q <= 1'b1;
				esc_q <= 1'b0;
				fill_q <= '0;
				if (push) begin
					bank_q <= ~bank_q;
				end
			end else if (in_sync_q) begin
				if (!esc_q && in_byte == FESC_CODE) begin
					esc_q <= 1'b1;
				end else begin
					esc_q <= 1'b0;
					if (room) begin
						fill_q <= fill_q + FILL_W'(1);
						if (fill_q == '0) begin
							cmd_ok_q <= ((dec_byte[3:0] & CMD_NIBBLE_MASK) == CMD_DATA);
						end
					end else begin
						// overflow: drop the frame and wait for the next FEND
						in_sync_q <= 1'b0;
						fill_q <= '0;
					end
				end
			end
		end
	end

	// a bank stays busy from frame close until the drain side has read it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 2'b00;
		end else begin
			for (int b = 0; b < 2; b++) begin
				if (push && bank_q == b[0]) begin
					busy_q[b] <= 1'b1;
				end else if (rel.valid && rel.bank == b[0]) begin
					busy_q[b] <= 1'b0;
				end
			end
		end
	end
endmodule

// ----- rtl/kfd_back.sv -----
// Drain side: reads a closed frame's payload from the store one byte per cycle
// while fetching, packs 8-byte words and holds them in the output register. Depends on kfd_pkg.
module kfd_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kfd_pkg::desc_t             desc,
	input  logic                       desc_empty,
	output logic                       pop,
	output logic                       rd_en,
	output logic [kfd_pkg::RAM_AW-1:0] rd_addr,
	input  logic [kfd_pkg::BYTE_W-1:0] rd_data,
	output kfd_pkg::release_t          rel,
	input  logic [kfd_pkg::PORT_W-1:0] port_number,
	kfd_word_if.source                 out_ch
);
	import kfd_pkg::*;

	back_state_t state_q;
	back_state_t state_d;

	logic bank_q;
	logic [ADDR_W-1:0] plen_q;
	logic [ADDR_W-1:0] pos_q;
	logic [LANE_W-1:0] lane_q;
	logic [CNT_W-1:0] cnt_q;
	logic last_q;
	logic rd_v_s1;
	logic [LANE_W-1:0] lane_s1;
	logic [BYTES_PER_WORD-1:0][BYTE_W-1:0] pack_q;

	logic out_valid_q;
	logic [WORD_W-1:0] word_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic out_last_q;
	logic [PLEN_W-1:0] out_plen_q;

	logic [ADDR_W-1:0] next_pos;
	logic frame_end;
	logic word_end;
	logic out_free;
	logic load;

	assign next_pos = pos_q + ADDR_W'(1);
	assign frame_end = (next_pos == plen_q);
	assign word_end = (lane_q == LANE_W'(BYTES_PER_WORD - 1)) || frame_end;
	assign out_free = !out_valid_q || out_ch.ready;
	// payload starts after the command byte
	assign rd_addr = {bank_q, next_pos};

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!desc_empty) begin
					state_d = BK_FETCH;
				end
			end
			BK_FETCH: begin
				if (word_end) begin
					state_d = BK_WAIT;
				end
			end
			BK_WAIT: state_d = BK_LOAD;
			BK_LOAD: begin
				if (out_free) begin
					state_d = last_q ? BK_IDLE : BK_FETCH;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		rd_en = 1'b0;
		load = 1'b0;
		case (state_q)
			BK_IDLE: pop = !desc_empty;
			BK_FETCH: rd_en = 1'b1;
			BK_LOAD: load = out_free;
			default: begin
				pop = 1'b0;
			end
		endcase
		rel.valid = rd_en && frame_end;
		rel.bank = bank_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			rd_v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_en;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bank_q <= desc.bank;
			plen_q <= desc.plen;
			pos_q <= '0;
			lane_q <= '0;
		end
		if (rd_en) begin
			pos_q <= next_pos;
			lane_q <= lane_q + LANE_W'(1);
			if (word_end) begin
				cnt_q <= CNT_W'(lane_q) + CNT_W'(1);
				last_q <= frame_end;
			end
		end
		lane_s1 <= lane_q;
		// unused high bytes of a short word stay zero
		if (pop || load) begin
			pack_q <= '0;
		end else if (rd_v_s1) begin
			pack_q[lane_s1] <= rd_data;
		end
		if (load) begin
			word_q <= pack_q;
			out_cnt_q <= cnt_q;
			out_last_q <= last_q;
			out_plen_q <= PLEN_W'(plen_q);
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.frame_word = word_q;
	assign out_ch.byte_count = out_cnt_q;
	assign out_ch.last_word = out_last_q;
	assign out_ch.payload_length = out_plen_q;
	assign out_ch.port_out = port_number;
endmodule

// ----- rtl/kiss_frame_deframer_unit.sv -----
// Top level of the KISS frame deframer: receive side, descriptor queue,
// drain side and the double-banked frame store. Depends on kfd_pkg, kfd_ifs.
//
// Takes one received serial byte per cycle, strips FEND/FESC framing and emits
// the payload of each data frame as 8-byte words tagged with length, port and
// a last-word flag. The frame store holds two banks of 512 bytes: one fills
// while the other drains, so input stalls only when both banks hold closed
// frames still waiting to drain. Draining is set by the single store read
// port: one byte per cycle while a word is fetched, then a wait state and a
// load state per word, the load waiting until the output register is free.
// The port number is written through the cfg channel, which is always ready;
// it is reported live on every word.
module kiss_frame_deframer_unit (
	input  logic      clk,
	input  logic      arst_n,
	kfd_byte_if.sink  in_ch,
	kfd_word_if.source out_ch,
	kfd_cfg_if.sink   cfg
);
	import kfd_pkg::*;

	logic [PORT_W-1:0] port_q;

	logic wr_en;
	logic [RAM_AW-1:0] wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic rd_en;
	logic [RAM_AW-1:0] rd_addr;
	logic [BYTE_W-1:0] rd_data;

	logic push;
	desc_t push_desc;
	logic pop;
	desc_t head_desc;
	logic desc_empty;
	release_t rel;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_q <= '0;
		end else if (cfg.valid) begin
			port_q <= cfg.port_number;
		end
	end

	kfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_byte   (in_ch.rx_byte),
		.in_ready  (in_ch.ready),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.push      (push),
		.push_desc (push_desc),
		.rel       (rel)
	);

	kfd_desc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_desc),
		.pop    (pop),
		.rdata  (head_desc),
		.empty  (desc_empty)
	);

	kfd_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	kfd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.desc        (head_desc),
		.desc_empty  (desc_empty),
		.pop         (pop),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.rel         (rel),
		.port_number (port_q),
		.out_ch      (out_ch)
	);
endmodule

// ----- rtl/kfd_checker.sv -----
// Port-level checks on the word output of the KISS frame deframer, bound to
// the top level. Depends on kfd_pkg and kiss_frame_deframer_unit.
module kfd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [kfd_pkg::CNT_W-1:0]  byte_count,
	input logic                       last_word,
	input logic [kfd_pkg::PLEN_W-1:0] payload_length
);
	import kfd_pkg::*;

	// hold a stalled word
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("word dropped while stalled");

	a_word_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(payload_length) && $stable(last_word))
		else $error("stalled word changed");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (byte_count != '0) && (byte_count <= CNT_W'(BYTES_PER_WORD)))
		else $error("byte count out of range");

	// only the final word of a frame may be short
	a_full_inner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_word |-> byte_count == CNT_W'(BYTES_PER_WORD))
		else $error("short word before end of frame");
endmodule

bind kiss_frame_deframer_unit kfd_checker u_kfd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.byte_count     (out_ch.byte_count),
	.last_word      (out_ch.last_word),
	.payload_length (out_ch.payload_length)
);

// ----- tb/kfd_word_checker.sv -----
`timescale 1ns / 100ps
// Frame word checker for the KISS frame deframer: watches the byte, word and port
// channels, rebuilds the expected frame words and compares. Depends on kfd_pkg, kfd_ifs.
module kfd_word_checker
	import kfd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	kfd_byte_if  byte_mon,
	kfd_word_if  word_mon,
	kfd_cfg_if   cfg_mon,
	output int   mismatch_count,
	output int   pending_count,
	output int   words_checked,
	output int   frames_emitted,
	output int   store_overflows,
	output int   bytes_taken
);

	typedef struct packed {
		logic [WORD_W-1:0] data;
		logic [CNT_W-1:0]  count;
		logic              last;
		logic [PLEN_W-1:0] plen;
		logic [PORT_W-1:0] port;
	} frame_word_t;

	logic [BYTE_W-1:0] frame_buf [FRAME_BYTES];
	int                fill;
	logic              in_sync;
	logic              escaped;
	logic [PORT_W-1:0] port_reg;
	frame_word_t       expected_words [$];

	// Decode one received byte; on a closing FEND queue the frame's payload words.
	task automatic absorb_byte(input logic [BYTE_W-1:0] raw);
		logic [BYTE_W-1:0] value;
		logic              keep;
		int                plen;
		int                pos;
		int                take;
		frame_word_t       w;
		value = raw;
		keep = 1'b0;
		if (raw == FEND_CODE) begin
			if (in_sync && fill > 1 && (frame_buf[0][3:0] & CMD_NIBBLE_MASK) == CMD_DATA) begin
				plen = fill - 1;
				pos = 0;
				while (pos < plen) begin
					take = (plen - pos > BYTES_PER_WORD) ? BYTES_PER_WORD : plen - pos;
					w.data = '0;
					for (int k = 0; k < take; k++)
						w.data[BYTE_W*k +: BYTE_W] = frame_buf[1 + pos + k];
					pos += take;
					w.count = CNT_W'(take);
					w.last = (pos >= plen);
					w.plen = PLEN_W'(plen);
					w.port = port_reg;
					expected_words.push_back(w);
				end
				frames_emitted++;
			end
			in_sync = 1'b1;
			fill = 0;
			escaped = 1'b0;
		end else if (in_sync) begin
			if (escaped) begin
				if (raw == TFEND_CODE)
					value = FEND_CODE;
				else if (raw == TFESC_CODE)
					value = FESC_CODE;
				escaped = 1'b0;
				keep = 1'b1;
			end else if (raw == FESC_CODE) begin
				escaped = 1'b1;
			end else begin
				keep = 1'b1;
			end
			if (keep) begin
				if (fill < FRAME_BYTES) begin
					frame_buf[fill] = value;
					fill++;
				end else begin
					// drop the frame and wait for the next FEND
					in_sync = 1'b0;
					fill = 0;
					store_overflows++;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_word_t got;
		frame_word_t want;
		if (!arst_n) begin
			fill = 0;
			in_sync = 1'b0;
			escaped = 1'b0;
			port_reg = '0;
			expected_words.delete();
			mismatch_count = 0;
			pending_count = 0;
			words_checked = 0;
			frames_emitted = 0;
			store_overflows = 0;
			bytes_taken = 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready)
				port_reg = cfg_mon.port_number;
			if (byte_mon.valid && byte_mon.ready) begin
				absorb_byte(byte_mon.rx_byte);
				bytes_taken++;
			end
			if (word_mon.valid && word_mon.ready) begin
				got.data = word_mon.frame_word;
				got.count = word_mon.byte_count;
				got.last = word_mon.last_word;
				got.plen = word_mon.payload_length;
				got.port = word_mon.port_out;
				if (expected_words.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected frame word data=%h count=%0d last=%0b len=%0d port=%0d",
						$time, got.data, got.count, got.last, got.plen, got.port);
				end else begin
					want = expected_words.pop_front();
					words_checked++;
					if (got !== want) begin
						mismatch_count++;
						$display("%0t: frame word mismatch", $time);
						$display("  expected data=%h count=%0d last=%0b len=%0d port=%0d",
							want.data, want.count, want.last, want.plen, want.port);
						$display("  actual   data=%h count=%0d last=%0b len=%0d port=%0d",
							got.data, got.count, got.last, got.plen, got.port);
					end
				end
			end
			pending_count = expected_words.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the KISS frame deframer testbench: clock, reset, byte and port stimulus
// and the word receiver. Depends on kfd_pkg, kfd_ifs, kfd_word_checker and the block.
module tb_top;
	import kfd_pkg::*;

	localparam int SETTLE_CYCLES = 64;
	localparam int HOLD_CYCLES = 400;
	localparam int TIMEOUT_NS = 5_000_000;

	localparam logic [BYTE_W-1:0] CMD_DATA_PORT0 = {4'h0, CMD_DATA};
	localparam logic [BYTE_W-1:0] CMD_DATA_PORT5 = {4'h5, CMD_DATA};
	localparam logic [BYTE_W-1:0] CMD_TXDELAY = 8'h01;
	localparam logic [BYTE_W-1:0] CMD_NIBBLE_FULL = {4'h0, CMD_NIBBLE_MASK};

	logic clk;
	logic arst_n;
	logic steady;
	logic hold_req;
	logic hold_taken;
	int   hold_left;
	int   items_sent;
	int   port_writes;

	int mismatch_count;
	int pending_count;
	int words_checked;
	int frames_emitted;
	int store_overflows;
	int bytes_taken;

	kfd_byte_if byte_ch ();
	kfd_word_if word_ch ();
	kfd_cfg_if  cfg_ch ();

	kiss_frame_deframer_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (byte_ch),
		.out_ch (word_ch),
		.cfg    (cfg_ch)
	);

	kfd_word_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_mon        (byte_ch),
		.word_mon        (word_ch),
		.cfg_mon         (cfg_ch),
		.mismatch_count  (mismatch_count),
		.pending_count   (pending_count),
		.words_checked   (words_checked),
		.frames_emitted  (frames_emitted),
		.store_overflows (store_overflows),
		.bytes_taken     (bytes_taken)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#(TIMEOUT_NS);
		$display("CHECK FAILED");
		$finish;
	end

	// Word receiver: random stalls, one long hold-off on request, none while steady.
	always @(negedge clk) begin
		if (!arst_n) begin
			word_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			word_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_taken) begin
			word_ch.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_taken <= 1'b1;
		end else if (steady) begin
			word_ch.ready <= 1'b1;
		end else begin
			word_ch.ready <= ($urandom_range(99) >= 34);
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] value);
		while (!steady && $urandom_range(99) < 34) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.rx_byte <= value;
		do @(posedge clk); while (!byte_ch.ready);
		items_sent++;
		@(negedge clk);
	endtask

	// Stuff FEND and FESC; now and then escape an ordinary byte, which passes unchanged.
	task automatic send_escaped(input logic [BYTE_W-1:0] value);
		if (value == FEND_CODE) begin
			send_byte(FESC_CODE);
			send_byte(TFEND_CODE);
		end else if (value == FESC_CODE) begin
			send_byte(FESC_CODE);
			send_byte(TFESC_CODE);
		end else begin
			if (value != TFEND_CODE && value != TFESC_CODE && $urandom_range(99) < 5)
				send_byte(FESC_CODE);
			send_byte(value);
		end
	endtask

	function automatic logic [BYTE_W-1:0] payload_byte();
		case ($urandom_range(19))
			0: return FEND_CODE;
			1: return FESC_CODE;
			2: return TFEND_CODE;
			3: return TFESC_CODE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic write_port(input logic [PORT_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.port_number <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		port_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Hold the input idle until every expected word is out, then let the block drain.
	task automatic settle();
		byte_ch.valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_frame();
		int kind;
		int roll;
		int len;
		logic [BYTE_W-1:0] cmd;
		kind = $urandom_range(99);
		if (kind < 88) begin
			cmd = ($urandom_range(99) < 80) ? {4'($urandom_range(15)), CMD_DATA}
				: 8'($urandom_range(255));
			roll = $urandom_range(99);
			if (roll < 10)
				len = 0;
			else if (roll < 80)
				len = $urandom_range(1, 16);
			else if (roll < 95)
				len = $urandom_range(17, 64);
			else
				len = $urandom_range(65, 160);
			send_escaped(cmd);
			repeat (len) send_escaped(payload_byte());
			// cut some frames on a dangling escape
			if (kind >= 80)
				send_byte(FESC_CODE);
			send_byte(FEND_CODE);
		end else begin
			repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
			send_byte(FEND_CODE);
		end
	endtask

	task automatic random_phase(input int budget);
		int start;
		start = items_sent;
		send_byte(FEND_CODE);
		while (items_sent - start < budget)
			random_frame();
	endtask

	initial begin
		logic [BYTE_W-1:0] opening [$];
		arst_n = 1'b0;
		steady = 1'b0;
		hold_req = 1'b0;
		hold_taken = 1'b0;
		hold_left = 0;
		items_sent = 0;
		port_writes = 0;
		byte_ch.valid = 1'b0;
		byte_ch.rx_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.port_number = '0;
		word_ch.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_port(8'h00);
		// unsynced bytes, empty and command-only frames, escapes, non-data commands
		opening = '{8'h00, 8'hFF, FESC_CODE, TFEND_CODE, FEND_CODE, FEND_CODE,
			CMD_DATA_PORT0, FEND_CODE,
			CMD_DATA_PORT0, 8'hFF, 8'h00, FEND_CODE,
			CMD_DATA_PORT5, FESC_CODE, TFEND_CODE, FESC_CODE, TFESC_CODE, FESC_CODE, 8'h41,
			FEND_CODE,
			CMD_DATA_PORT0, 8'h11, FESC_CODE, FEND_CODE,
			CMD_NIBBLE_FULL, 8'h22, FEND_CODE,
			CMD_TXDELAY, 8'h33, FEND_CODE};
		foreach (opening[i])
			send_byte(opening[i]);
		send_byte(CMD_DATA_PORT0);
		for (int i = 1; i <= 8; i++)
			send_byte(8'(8'hA0 + i));
		send_byte(FEND_CODE);
		send_byte(CMD_DATA_PORT0);
		for (int i = 1; i <= 9; i++)
			send_byte(8'(8'h50 + i));
		send_byte(FEND_CODE);
		settle();

		write_port(8'($urandom_range(1, 254)));
		hold_req <= 1'b1;
		random_phase(100);
		settle();

		steady <= 1'b1;
		write_port(8'($urandom_range(255)));
		random_phase(90);
		settle();

		steady <= 1'b0;
		write_port(8'h01);
		random_phase(90);
		settle();

		$display("Run covered %0d received bytes under %0d port settings.", bytes_taken,
			port_writes);
		$display("%0d frames came out as %0d words; %0d frames overflowed the store.",
			frames_emitted, words_checked, store_overflows);
		if (mismatch_count == 0 && pending_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
